/* rtl/pwc_pkg.sv */
// Shared types, register codes and fixed-point helpers for the particle wall
// collision and integration core. No dependencies.
package pwc_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_FLOOR_LEVEL     = 4'd0,
        REG_LEFT_WALL       = 4'd1,
        REG_RIGHT_WALL      = 4'd2,
        REG_GRAVITY_Y       = 4'd3,
        REG_BOUNCE_FACTOR   = 4'd4,
        REG_FRICTION_FACTOR = 4'd5,
        REG_ACCEL_LIMIT     = 4'd6,
        REG_SPEED_LIMIT     = 4'd7
    } pwc_reg_t;

    // Configuration register file as seen by the datapath.
    typedef struct packed {
        logic signed [31:0] floor_level;
        logic signed [31:0] left_wall;
        logic signed [31:0] right_wall;
        logic signed [31:0] gravity_y;
        logic [16:0]        bounce_factor;
        logic [16:0]        friction_factor;
        logic [30:0]        accel_limit;
        logic [30:0]        speed_limit;
    } pwc_cfg_t;

    // Position and velocity of one particle.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } pwc_kin_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (x < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    // Add half an LSB, drop frac low bits toward minus infinity, saturate.
    function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] x,
                                                   input int unsigned frac);
        logic signed [65:0] t;
        t = (x + (66'sd1 <<< (frac - 1))) >>> frac;
        return sat32(t);
    endfunction

endpackage

/* rtl/pwc_collide.sv */
// Boundary tests and impulse arithmetic: clamps the position against floor and
// walls and forms the total acceleration. Depends on pwc_pkg.
module pwc_collide import pwc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  pwc_cfg_t           cfg,
    input  logic               in_valid,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [30:0]        particle_mass,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    output logic               out_valid,
    output pwc_kin_t           out_kin,
    output logic signed [31:0] out_ax,
    output logic signed [31:0] out_ay
);

    localparam int NST = 7;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               hf;
        logic               hl;
        logic               hr;
        logic signed [65:0] wf;
        logic signed [65:0] wl;
        logic signed [65:0] wr;
        logic signed [31:0] jf;
        logic signed [31:0] jl;
        logic signed [31:0] jr;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } col_st_t;

    col_st_t          st_reg  [NST];
    col_st_t          st_next [NST];
    logic [NST-1:0]   vld_reg;

    logic signed [31:0] px_left;
    logic signed [31:0] mass_s;
    logic signed [32:0] vx_ext;
    logic signed [32:0] vy_ext;
    logic signed [32:0] vx_neg;
    logic signed [33:0] one_b;
    logic signed [17:0] fric_s;
    logic signed [65:0] sum_x;
    logic signed [65:0] sum_y;

    // Friction acts against the incoming tangential speed.
    function automatic logic signed [32:0] fric(input logic signed [31:0] fj,
                                                input logic signed [31:0] vt);
        if (vt > 32'sd0) begin
            return -33'(fj);
        end else if (vt < 32'sd0) begin
            return 33'(fj);
        end
        return 33'sd0;
    endfunction

    assign mass_s = $signed({1'b0, particle_mass});
    assign vx_ext = {vel_x[31], vel_x};
    assign vy_ext = {vel_y[31], vel_y};
    assign vx_neg = -vx_ext;
    assign one_b  = (34'sd1 <<< FRAC_BITS) + $signed({17'b0, cfg.bounce_factor});
    assign fric_s = $signed({1'b0, cfg.friction_factor});
    assign px_left = (pos_x < cfg.left_wall) ? cfg.left_wall : pos_x;

    always_comb begin
        // Boundary tests and momentum products.
        st_next[0]    = '0;
        st_next[0].hf = pos_y < cfg.floor_level;
        st_next[0].hl = pos_x < cfg.left_wall;
        st_next[0].hr = px_left > cfg.right_wall;
        st_next[0].px = (px_left > cfg.right_wall) ? cfg.right_wall : px_left;
        st_next[0].py = (pos_y < cfg.floor_level) ? cfg.floor_level : pos_y;
        st_next[0].vx = vel_x;
        st_next[0].vy = vel_y;
        st_next[0].fx = force_x;
        st_next[0].fy = force_y;
        st_next[0].wf = mass_s * vy_ext;
        st_next[0].wl = mass_s * vx_ext;
        st_next[0].wr = mass_s * vx_neg;

        // Momentum rounded to Q format.
        st_next[1]    = st_reg[0];
        st_next[1].wf = 66'(rnd_sat(st_reg[0].wf, FRAC_BITS));
        st_next[1].wl = 66'(rnd_sat(st_reg[0].wl, FRAC_BITS));
        st_next[1].wr = 66'(rnd_sat(st_reg[0].wr, FRAC_BITS));

        // Scale by one plus restitution; the momentum is a signed value.
        st_next[2]    = st_reg[1];
        st_next[2].wf = one_b * $signed(st_reg[1].wf[31:0]);
        st_next[2].wl = one_b * $signed(st_reg[1].wl[31:0]);
        st_next[2].wr = one_b * $signed(st_reg[1].wr[31:0]);

        // Normal impulse.
        st_next[3]    = st_reg[2];
        st_next[3].jf = rnd_sat(-st_reg[2].wf, FRAC_BITS);
        st_next[3].jl = rnd_sat(-st_reg[2].wl, FRAC_BITS);
        st_next[3].jr = rnd_sat(-st_reg[2].wr, FRAC_BITS);

        // Friction products.
        st_next[4]    = st_reg[3];
        st_next[4].wf = fric_s * st_reg[3].jf;
        st_next[4].wl = fric_s * st_reg[3].jl;
        st_next[4].wr = fric_s * st_reg[3].jr;

        // Friction impulse.
        st_next[5]    = st_reg[4];
        st_next[5].wf = 66'(rnd_sat(st_reg[4].wf, FRAC_BITS));
        st_next[5].wl = 66'(rnd_sat(st_reg[4].wl, FRAC_BITS));
        st_next[5].wr = 66'(rnd_sat(st_reg[4].wr, FRAC_BITS));

        // Total acceleration, saturated.
        sum_x = 66'(st_reg[5].fx);
        sum_y = 66'(st_reg[5].fy) + 66'(cfg.gravity_y);
        if (st_reg[5].hf) begin
            sum_y = sum_y + 66'(st_reg[5].jf);
            sum_x = sum_x + 66'(fric(st_reg[5].wf[31:0], st_reg[5].vx));
        end
        if (st_reg[5].hl) begin
            sum_x = sum_x + 66'(st_reg[5].jl);
            sum_y = sum_y + 66'(fric(st_reg[5].wl[31:0], st_reg[5].vy));
        end
        if (st_reg[5].hr) begin
            sum_x = sum_x - 66'(st_reg[5].jr);
            sum_y = sum_y + 66'(fric(st_reg[5].wr[31:0], st_reg[5].vy));
        end
        st_next[6]    = st_reg[5];
        st_next[6].ax = sat32(sum_x);
        st_next[6].ay = sat32(sum_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign out_kin.px = st_reg[NST-1].px;
    assign out_kin.py = st_reg[NST-1].py;
    assign out_kin.vx = st_reg[NST-1].vx;
    assign out_kin.vy = st_reg[NST-1].vy;
    assign out_ax     = st_reg[NST-1].ax;
    assign out_ay     = st_reg[NST-1].ay;

endmodule

/* rtl/pwc_limit.sv */
// Vector magnitude limiter: squared length, pipelined integer square root and
// pipelined restoring divide for the rescale. Depends on pwc_pkg.
module pwc_limit import pwc_pkg::*; #(
    parameter int SIDE_W = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [30:0]        lim,
    input  logic               in_valid,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [SIDE_W-1:0]  out_side
);

    localparam int RBITS  = 32;
    localparam int SQ0    = 3;
    localparam int MUL_ST = SQ0 + RBITS;
    localparam int DIV0   = MUL_ST + 1;
    localparam int FIN_ST = DIV0 + RBITS;
    localparam int NST    = FIN_ST + 1;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic [31:0]        ux;
        logic [31:0]        uy;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        ll;
        logic               big;
        logic [63:0]        acc;
        logic [63:0]        root;
        logic [63:0]        nx;
        logic [63:0]        ny;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [31:0]        qx;
        logic [31:0]        qy;
        logic [SIDE_W-1:0]  side;
    } lim_st_t;

    lim_st_t        st_reg  [NST];
    lim_st_t        st_next [NST];
    logic [NST-1:0] vld_reg;

    always_comb begin
        logic [63:0] bitv;
        logic [63:0] trial;
        logic [32:0] shx;
        logic [32:0] shy;
        logic [32:0] mag;

        // Magnitudes of both components.
        st_next[0]      = '0;
        st_next[0].ox   = in_x;
        st_next[0].oy   = in_y;
        st_next[0].ux   = in_x[31] ? (~in_x + 32'd1) : in_x;
        st_next[0].uy   = in_y[31] ? (~in_y + 32'd1) : in_y;
        st_next[0].side = in_side;

        // Squares and squared limit.
        st_next[1]     = st_reg[0];
        st_next[1].sqx = 64'(st_reg[0].ux) * 64'(st_reg[0].ux);
        st_next[1].sqy = 64'(st_reg[0].uy) * 64'(st_reg[0].uy);
        st_next[1].ll  = 64'(lim) * 64'(lim);

        // Squared length and the over-limit test.
        st_next[2]      = st_reg[1];
        st_next[2].acc  = st_reg[1].sqx + st_reg[1].sqy;
        st_next[2].big  = (st_reg[1].sqx + st_reg[1].sqy) > st_reg[1].ll;
        st_next[2].root = '0;

        // Square root, one result bit per stage.
        for (int i = 0; i < RBITS; i++) begin
            bitv  = 64'd1 << (62 - 2 * i);
            trial = st_reg[SQ0-1+i].root + bitv;
            st_next[SQ0+i] = st_reg[SQ0-1+i];
            if (st_reg[SQ0-1+i].acc >= trial) begin
                st_next[SQ0+i].acc  = st_reg[SQ0-1+i].acc - trial;
                st_next[SQ0+i].root = (st_reg[SQ0-1+i].root >> 1) + bitv;
            end else begin
                st_next[SQ0+i].root = st_reg[SQ0-1+i].root >> 1;
            end
        end

        // Numerators |c| * limit.
        st_next[MUL_ST]    = st_reg[MUL_ST-1];
        st_next[MUL_ST].nx = 64'(st_reg[MUL_ST-1].ux) * 64'(lim);
        st_next[MUL_ST].ny = 64'(st_reg[MUL_ST-1].uy) * 64'(lim);

        // Restoring divide by the magnitude. The quotient never exceeds the
        // component magnitude, so the high numerator word is already a
        // partial remainder.
        for (int i = 0; i < RBITS; i++) begin
            st_next[DIV0+i] = st_reg[DIV0-1+i];
            mag = {1'b0, st_reg[DIV0-1+i].root[31:0]};
            if (i == 0) begin
                shx = {st_reg[DIV0-1].nx[62:32], st_reg[DIV0-1].nx[31]};
                shy = {st_reg[DIV0-1].ny[62:32], st_reg[DIV0-1].ny[31]};
            end else begin
                shx = {st_reg[DIV0-1+i].rx, st_reg[DIV0-1+i].nx[31-i]};
                shy = {st_reg[DIV0-1+i].ry, st_reg[DIV0-1+i].ny[31-i]};
            end
            if (shx >= mag) begin
                st_next[DIV0+i].rx        = 32'(shx - mag);
                st_next[DIV0+i].qx[31-i]  = 1'b1;
            end else begin
                st_next[DIV0+i].rx        = shx[31:0];
                st_next[DIV0+i].qx[31-i]  = 1'b0;
            end
            if (shy >= mag) begin
                st_next[DIV0+i].ry        = 32'(shy - mag);
                st_next[DIV0+i].qy[31-i]  = 1'b1;
            end else begin
                st_next[DIV0+i].ry        = shy[31:0];
                st_next[DIV0+i].qy[31-i]  = 1'b0;
            end
        end

        // Restore signs, or pass the vector when under the limit.
        st_next[FIN_ST] = st_reg[FIN_ST-1];
        if (st_reg[FIN_ST-1].big) begin
            st_next[FIN_ST].ox = st_reg[FIN_ST-1].ox[31] ? -st_reg[FIN_ST-1].qx
                                                         : st_reg[FIN_ST-1].qx;
            st_next[FIN_ST].oy = st_reg[FIN_ST-1].oy[31] ? -st_reg[FIN_ST-1].qy
                                                         : st_reg[FIN_ST-1].qy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_x     = st_reg[NST-1].ox;
    assign out_y     = st_reg[NST-1].oy;
    assign out_side  = st_reg[NST-1].side;

endmodule

/* rtl/particle_wall_collide_integrate_core.sv */
// Accepts one item per cycle while the skid register is empty.
// Stages: 7 collision, 69 acceleration limiter, 1 velocity add, 69 speed
// limiter, 1 output register. The limiter depth is set by its 32-stage square
// root and 32-stage divider. An output skid register keeps input flowing while
// one result waits. Reset (aresetn low, synchronous) clears all valid bits and
// loads the configuration registers with their default values.
module particle_wall_collide_integrate_core import pwc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic [30:0]        s_particle_mass,
    input  logic signed [31:0] s_force_x,
    input  logic signed [31:0] s_force_y,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y
);

    // Default register values, scaled to the fraction width.
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam logic signed [31:0] FLOOR_RST = 32'(80 * ONE);
    localparam logic signed [31:0] RIGHT_RST = 32'(240 * ONE);
    localparam logic signed [31:0] GRAV_RST  = 32'(-((479 * ONE + 500) / 1000));
    localparam logic [16:0]        COEF_RST  = 17'((2 * ONE + 5) / 10);
    localparam logic [30:0]        LIM_RST   = 31'(10 * ONE);

    pwc_cfg_t           cfg_reg;

    logic               en;
    logic               col_valid;
    pwc_kin_t           col_kin;
    logic signed [31:0] col_ax;
    logic signed [31:0] col_ay;

    logic               al_valid;
    logic signed [31:0] al_x;
    logic signed [31:0] al_y;
    pwc_kin_t           al_side;

    logic               vel_valid_reg;
    pwc_kin_t           vel_reg;
    pwc_kin_t           vel_next;

    logic               sl_valid;
    logic signed [31:0] sl_x;
    logic signed [31:0] sl_y;
    logic [63:0]        sl_side;

    pwc_kin_t           res_next;
    pwc_kin_t           out_reg;
    pwc_kin_t           skid_reg;
    logic               m_valid_reg;
    logic               skid_valid_reg;

    // Configuration writes are always taken; the user must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.floor_level     <= FLOOR_RST;
            cfg_reg.left_wall       <= '0;
            cfg_reg.right_wall      <= RIGHT_RST;
            cfg_reg.gravity_y       <= GRAV_RST;
            cfg_reg.bounce_factor   <= COEF_RST;
            cfg_reg.friction_factor <= COEF_RST;
            cfg_reg.accel_limit     <= LIM_RST;
            cfg_reg.speed_limit     <= LIM_RST;
        end else if (cfg_valid) begin
            unique case (pwc_reg_t'(cfg_index))
                REG_FLOOR_LEVEL:     cfg_reg.floor_level     <= cfg_data;
                REG_LEFT_WALL:       cfg_reg.left_wall       <= cfg_data;
                REG_RIGHT_WALL:      cfg_reg.right_wall      <= cfg_data;
                REG_GRAVITY_Y:       cfg_reg.gravity_y       <= cfg_data;
                REG_BOUNCE_FACTOR:   cfg_reg.bounce_factor   <= cfg_data[16:0];
                REG_FRICTION_FACTOR: cfg_reg.friction_factor <= cfg_data[16:0];
                REG_ACCEL_LIMIT:     cfg_reg.accel_limit     <= cfg_data[30:0];
                REG_SPEED_LIMIT:     cfg_reg.speed_limit     <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together and only stops once the skid
    // register is holding a result, so the enable comes straight from a flop.
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    pwc_collide #(
        .FRAC_BITS(FRAC_BITS)
    ) u_collide (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .cfg           (cfg_reg),
        .in_valid      (s_valid),
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .vel_x         (s_vel_x),
        .vel_y         (s_vel_y),
        .particle_mass (s_particle_mass),
        .force_x       (s_force_x),
        .force_y       (s_force_y),
        .out_valid     (col_valid),
        .out_kin       (col_kin),
        .out_ax        (col_ax),
        .out_ay        (col_ay)
    );

    // Acceleration limiter; position and velocity ride along as side data.
    pwc_limit #(
        .SIDE_W($bits(pwc_kin_t))
    ) u_accel_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .lim       (cfg_reg.accel_limit),
        .in_valid  (col_valid),
        .in_x      (col_ax),
        .in_y      (col_ay),
        .in_side   (col_kin),
        .out_valid (al_valid),
        .out_x     (al_x),
        .out_y     (al_y),
        .out_side  (al_side)
    );

    // Velocity update with saturation.
    always_comb begin
        vel_next    = al_side;
        vel_next.vx = sat32(66'(al_side.vx) + 66'(al_x));
        vel_next.vy = sat32(66'(al_side.vy) + 66'(al_y));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_valid_reg <= 1'b0;
        end else if (en) begin
            vel_valid_reg <= al_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vel_reg <= vel_next;
        end
    end

    // Speed limiter; the clamped position rides along.
    pwc_limit #(
        .SIDE_W(64)
    ) u_speed_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .lim       (cfg_reg.speed_limit),
        .in_valid  (vel_valid_reg),
        .in_x      (vel_reg.vx),
        .in_y      (vel_reg.vy),
        .in_side   ({vel_reg.px, vel_reg.py}),
        .out_valid (sl_valid),
        .out_x     (sl_x),
        .out_y     (sl_y),
        .out_side  (sl_side)
    );

    // Euler position step.
    always_comb begin
        res_next.vx = sl_x;
        res_next.vy = sl_y;
        res_next.px = sat32(66'($signed(sl_side[63:32])) + 66'(sl_x));
        res_next.py = sat32(66'($signed(sl_side[31:0])) + 66'(sl_y));
    end

    // Output register plus one skid entry. A result leaving the pipeline goes
    // to the output register when that is free or being drained, otherwise it
    // parks in the skid register, which then holds the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (sl_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (sl_valid) begin
            if (!m_valid_reg || m_ready) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_pos_x = out_reg.px;
    assign m_new_pos_y = out_reg.py;
    assign m_new_vel_x = out_reg.vx;
    assign m_new_vel_y = out_reg.vy;

    // The skid entry is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds an item while the output is empty");

    // A blocked output with a new result arriving must park it in the skid.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (sl_valid && en && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result dropped while the output was stalled");

    // Draining the skid keeps the output occupied on the next cycle.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (m_valid_reg && !skid_valid_reg))
        else $error("skid item lost on drain");

    // With the output free, a result leaving the pipeline is shown next cycle.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (sl_valid && en && !m_valid_reg) |=> (m_valid_reg && !skid_valid_reg))
        else $error("result not loaded into a free output register");

endmodule

/* verif/tb.sv */
// Self-checking testbench for particle_wall_collide_integrate_core.
// Depends on rtl/pwc_pkg.sv and the core RTL; runs directed and random particles.
module tb;
    import pwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Settle time covers the core's input-to-result delay with a margin on top.
    localparam int SETTLE_CYCLES = 160;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    // One particle as it enters the core.
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        mass;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } particle_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0;
    logic signed [31:0] s_pos_y = '0;
    logic signed [31:0] s_vel_x = '0;
    logic signed [31:0] s_vel_y = '0;
    logic [30:0]        s_particle_mass = '0;
    logic signed [31:0] s_force_x = '0;
    logic signed [31:0] s_force_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_new_pos_x;
    logic signed [31:0] m_new_pos_y;
    logic signed [31:0] m_new_vel_x;
    logic signed [31:0] m_new_vel_y;

    // Shadow copy of the configuration registers, updated as each write is accepted.
    pwc_cfg_t  wall_cfg;
    // Expected particle states, oldest first.
    pwc_kin_t  expected_kin[$];
    int        mismatches = 0;
    // When set, neither side idles; this gives a long back-to-back stretch.
    bit        steady = 1'b0;

    always #1 aclk = ~aclk;

    particle_wall_collide_integrate_core #(.FRAC_BITS(16)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y),
        .s_particle_mass(s_particle_mass),
        .s_force_x(s_force_x), .s_force_y(s_force_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_pos_x(m_new_pos_x), .m_new_pos_y(m_new_pos_y),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y)
    );

    // ------------------------------------------------------------------
    // Predictor: 64-bit integer arithmetic, wide enough that no
    // intermediate product can overflow before it is saturated.
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint x);
        if (x > MAX32) return MAX32;
        if (x < MIN32) return MIN32;
        return x;
    endfunction

    // Round half up in Q16.16, then saturate.
    function automatic longint round_q16(longint x);
        return clamp32((x + 64'sd32768) >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale the vector back onto the limit circle when it lies outside it.
    function automatic void clip_magnitude(inout longint x, inout longint y,
                                           input longint unsigned lim);
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned sq;
        longint unsigned mag;
        ux = (x < 0) ? longint'(-x) : longint'(x);
        uy = (y < 0) ? longint'(-y) : longint'(y);
        sq = ux * ux + uy * uy;
        if (sq > lim * lim) begin
            mag = int_sqrt(sq);
            x = (x < 0) ? -longint'(ux * lim / mag) : longint'(ux * lim / mag);
            y = (y < 0) ? -longint'(uy * lim / mag) : longint'(uy * lim / mag);
        end
    endfunction

    // Normal impulse j = -(1 + bounce) * mass * vn, rounded at each product.
    function automatic longint wall_impulse(longint mass, longint vn);
        longint mom;
        mom = round_q16(mass * vn);
        return round_q16(-((64'sd65536 + longint'(wall_cfg.bounce_factor)) * mom));
    endfunction

    // Friction opposes the tangential speed; none when that speed is zero.
    function automatic longint wall_friction(longint j, longint vt);
        longint fj;
        fj = round_q16(longint'(wall_cfg.friction_factor) * j);
        if (vt > 0) return -fj;
        if (vt < 0) return fj;
        return 0;
    endfunction

    function automatic pwc_kin_t integrate_particle(particle_t p);
        longint px, py, vx, vy, ax, ay, j;
        pwc_kin_t k;
        px = p.px;
        py = p.py;
        vx = p.vx;
        vy = p.vy;
        ax = p.fx;
        ay = longint'(p.fy) + longint'(wall_cfg.gravity_y);
        if (py < wall_cfg.floor_level) begin
            py = wall_cfg.floor_level;
            j = wall_impulse(p.mass, vy);
            ay += j;
            ax += wall_friction(j, vx);
        end
        if (px < wall_cfg.left_wall) begin
            px = wall_cfg.left_wall;
            j = wall_impulse(p.mass, vx);
            ax += j;
            ay += wall_friction(j, vy);
        end
        // The right wall sees the position already clamped by the left wall.
        if (px > wall_cfg.right_wall) begin
            px = wall_cfg.right_wall;
            j = wall_impulse(p.mass, -vx);
            ax -= j;
            ay += wall_friction(j, vy);
        end
        ax = clamp32(ax);
        ay = clamp32(ay);
        clip_magnitude(ax, ay, wall_cfg.accel_limit);
        vx = clamp32(vx + ax);
        vy = clamp32(vy + ay);
        clip_magnitude(vx, vy, wall_cfg.speed_limit);
        k.px = 32'(clamp32(px + vx));
        k.py = 32'(clamp32(py + vy));
        k.vx = 32'(vx);
        k.vy = 32'(vy);
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard check.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pwc_kin_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_kin.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result item arrived with none expected");
            end else begin
                want = expected_kin.pop_front();
                check_field("new_pos_x", want.px, m_new_pos_x);
                check_field("new_pos_y", want.py, m_new_pos_y);
                check_field("new_vel_x", want.vx, m_new_vel_x);
                check_field("new_vel_y", want.vy, m_new_vel_y);
            end
        end
        // The receiver stalls about 11 percent of the time unless steady is set.
        m_ready <= steady || ($urandom_range(99) >= 11);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    // Sends one item; valid stays high afterwards so items can stream back to back.
    task automatic send_particle(particle_t p);
        while (!steady && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= p.px;
        s_pos_y <= p.py;
        s_vel_x <= p.vx;
        s_vel_y <= p.vy;
        s_particle_mass <= p.mass;
        s_force_x <= p.fx;
        s_force_y <= p.fy;
        do @(posedge aclk); while (!s_ready);
        expected_kin = {expected_kin, integrate_particle(p)};
    endtask

    // Lets every expected result come out and the pipeline empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_kin.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers are written only with the pipeline empty.
    task automatic write_reg(pwc_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FLOOR_LEVEL:     wall_cfg.floor_level = data;
            REG_LEFT_WALL:       wall_cfg.left_wall = data;
            REG_RIGHT_WALL:      wall_cfg.right_wall = data;
            REG_GRAVITY_Y:       wall_cfg.gravity_y = data;
            REG_BOUNCE_FACTOR:   wall_cfg.bounce_factor = data[16:0];
            REG_FRICTION_FACTOR: wall_cfg.friction_factor = data[16:0];
            REG_ACCEL_LIMIT:     wall_cfg.accel_limit = data[30:0];
            REG_SPEED_LIMIT:     wall_cfg.speed_limit = data[30:0];
            default: ;
        endcase
    endtask

    task automatic load_walls(logic [31:0] floor_y, logic [31:0] left_x, logic [31:0] right_x,
                              logic [31:0] grav, logic [31:0] bounce, logic [31:0] fric,
                              logic [31:0] amax, logic [31:0] vmax);
        drain_pipeline();
        write_reg(REG_FLOOR_LEVEL, floor_y);
        write_reg(REG_LEFT_WALL, left_x);
        write_reg(REG_RIGHT_WALL, right_x);
        write_reg(REG_GRAVITY_Y, grav);
        write_reg(REG_BOUNCE_FACTOR, bounce);
        write_reg(REG_FRICTION_FACTOR, fric);
        write_reg(REG_ACCEL_LIMIT, amax);
        write_reg(REG_SPEED_LIMIT, vmax);
    endtask

    function automatic particle_t make_particle(longint px, longint py, longint vx,
                                                longint vy, longint mass, longint fx,
                                                longint fy);
        particle_t p;
        p.px = 32'(px);
        p.py = 32'(py);
        p.vx = 32'(vx);
        p.vy = 32'(vy);
        p.mass = 31'(mass);
        p.fx = 32'(fx);
        p.fy = 32'(fy);
        return p;
    endfunction

    function automatic longint near_value(longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Most particles sit near a boundary with physical speeds, so collisions
    // happen often; the rest are raw bit patterns across the full range.
    function automatic particle_t random_particle();
        particle_t p;
        if ($urandom_range(9) < 3) begin
            p = make_particle($signed($urandom()), $signed($urandom()),
                              $signed($urandom()), $signed($urandom()),
                              $urandom() & 32'h7FFF_FFFF, $signed($urandom()),
                              $signed($urandom()));
            return p;
        end
        p = make_particle(
            (($urandom_range(1) == 0) ? longint'(wall_cfg.left_wall)
                                      : longint'(wall_cfg.right_wall))
                + near_value(20 * 65536),
            longint'(wall_cfg.floor_level) + near_value(20 * 65536),
            near_value(16 * 65536), near_value(16 * 65536),
            $urandom_range(4 * 65536),
            near_value(16 * 65536), near_value(16 * 65536));
        // A zero tangential speed now and then exercises the normal-only impulse.
        if ($urandom_range(7) == 0) p.vx = 0;
        if ($urandom_range(7) == 0) p.vy = 0;
        return p;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_particle(random_particle());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Reset values, field extremes, each wall, and the zero tangential speed case.
    task automatic test_directed_defaults();
        send_particle(make_particle(0, 0, 0, 0, 0, 0, 0));
        send_particle(make_particle(MAX32, MAX32, MAX32, MAX32, 31'h7FFF_FFFF, MAX32, MAX32));
        send_particle(make_particle(MIN32, MIN32, MIN32, MIN32, 31'h7FFF_FFFF, MIN32, MIN32));
        send_particle(make_particle(MIN32, MAX32, MAX32, MIN32, 0, MIN32, MAX32));
        // Floor hit, moving down, with and without sideways speed.
        send_particle(make_particle(100 << 16, 70 << 16, 2 << 16, -(5 << 16), 1 << 16, 0, 0));
        send_particle(make_particle(100 << 16, 70 << 16, -(2 << 16), -(5 << 16), 1 << 16, 0, 0));
        send_particle(make_particle(100 << 16, 70 << 16, 0, -(5 << 16), 1 << 16, 0, 0));
        // Left wall, right wall, and a corner.
        send_particle(make_particle(-(3 << 16), 90 << 16, -(4 << 16), 1 << 16, 2 << 16, 0, 0));
        send_particle(make_particle(-(3 << 16), 90 << 16, -(4 << 16), 0, 2 << 16, 0, 0));
        send_particle(make_particle(250 << 16, 90 << 16, 4 << 16, -(1 << 16), 2 << 16, 0, 0));
        send_particle(make_particle(250 << 16, 90 << 16, 4 << 16, 0, 2 << 16, 0, 0));
        send_particle(make_particle(-(1 << 16), 10 << 16, -(3 << 16), -(3 << 16), 1 << 16,
                                    5 << 16, 5 << 16));
        // Heavy particle so the impulse saturates, and large forces hitting the limiter.
        send_particle(make_particle(-(1 << 16), 10 << 16, MIN32, MIN32, 31'h7FFF_FFFF, 0, 0));
        send_particle(make_particle(100 << 16, 100 << 16, 0, 0, 1 << 16, 30 << 16, 40 << 16));
        send_particle(make_particle(100 << 16, 100 << 16, 9 << 16, 9 << 16, 1 << 16, 0, 0));
        send_particle(make_particle(100 << 16, 100 << 16, 1, -1, 1, 1, -1));
    endtask

    // Several register settings, the extremes among them.
    task automatic test_register_sweep();
        // No gravity, full restitution and friction, no limits.
        load_walls(0, -(50 << 16), 50 << 16, 0, 65536, 65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_particle(make_particle(0, -(1 << 16), 1 << 16, -(2 << 16), 1 << 16, 0, 0));
        send_random(60);
        // Walls crossed over and factors above one.
        load_walls(32'h8000_0000, 100 << 16, 20 << 16, -(1 << 16), 32'h1FFFF, 32'h1FFFF,
                   655360, 655360);
        send_particle(make_particle(50 << 16, 0, 3 << 16, 1 << 16, 1 << 16, 0, 0));
        send_particle(make_particle(10 << 16, 0, -(3 << 16), -(1 << 16), 1 << 16, 0, 0));
        send_random(60);
        // Zero limits force both vectors to zero.
        load_walls(32'h7FFF_FFFF, 0, 15728640, 32'h8000_0000, 0, 0, 0, 0);
        send_random(40);
        // Boundaries at the range ends, tiny acceleration limit.
        load_walls(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                   1, 32'h7FFF_FFFF);
        send_random(40);
    endtask

    // The long random run, beginning with a stretch free of idle cycles.
    task automatic test_random_stream();
        load_walls(5242880, 0, 15728640, -31392, 13107, 13107, 655360, 655360);
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;
        send_random(330);
    endtask

    initial begin
        wall_cfg.floor_level = 5242880;
        wall_cfg.left_wall = 0;
        wall_cfg.right_wall = 15728640;
        wall_cfg.gravity_y = -31392;
        wall_cfg.bounce_factor = 13107;
        wall_cfg.friction_factor = 13107;
        wall_cfg.accel_limit = 655360;
        wall_cfg.speed_limit = 655360;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_defaults();
        test_register_sweep();
        test_random_stream();
        drain_pipeline();
        if (mismatches == 0 && expected_kin.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
